// File: hw/rtl/fir_pkg.sv
// Frame index ring: shared types, codes and constants.
// No dependencies; read by every other file of the block.
package fir_pkg;

  localparam int TIME_W  = 63;
  localparam int CRC_W   = 32;
  localparam int CSIZE_W = 26;
  localparam int CNT_W   = 64;
  localparam int BYTE_W  = 48;
  localparam int STAT_W  = 3;
  localparam int ACT_W   = 2;
  localparam int CAP_W   = 13;
  localparam int KFI_W   = 10;
  localparam int CIDX_W  = 2;
  localparam int REMC_W  = 6;

  localparam logic [BYTE_W-1:0] MAX_READ_BYTES = BYTE_W'(100 * 1024 * 1024);

  localparam logic [ACT_W-1:0] ACT_FRAME  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RANGE  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
  localparam logic [STAT_W-1:0] STAT_DUP     = 3'd1;
  localparam logic [STAT_W-1:0] STAT_NOREC   = 3'd2;
  localparam logic [STAT_W-1:0] STAT_EMPTY   = 3'd3;
  localparam logic [STAT_W-1:0] STAT_BADSIZE = 3'd4;

  localparam logic [CIDX_W-1:0] REG_CAPACITY     = 2'd0;
  localparam logic [CIDX_W-1:0] REG_KEY_INTERVAL = 2'd1;

  localparam logic [3:0] OP_NONE      = 4'd0;
  localparam logic [3:0] OP_FRAME     = 4'd1;
  localparam logic [3:0] OP_PLAIN     = 4'd2;
  localparam logic [3:0] OP_SCAN_INIT = 4'd3;
  localparam logic [3:0] OP_SCAN      = 4'd4;
  localparam logic [3:0] OP_WALK_INIT = 4'd5;
  localparam logic [3:0] OP_WALK_RD   = 4'd6;
  localparam logic [3:0] OP_WALK_CHK  = 4'd7;
  localparam logic [3:0] OP_FIN_A     = 4'd8;
  localparam logic [3:0] OP_FIN_B     = 4'd9;
  localparam logic [3:0] OP_RNG_A     = 4'd10;
  localparam logic [3:0] OP_RNG_B     = 4'd11;
  localparam logic [3:0] OP_RNG_C     = 4'd12;
  localparam logic [3:0] OP_REM       = 4'd13;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [TIME_W-1:0]  event_time;
    logic [CRC_W-1:0]   frame_crc;
    logic               resized;
    logic               encoded;
    logic [CSIZE_W-1:0] coded_size;
  } item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  frame_no;
    logic              key_mark;
    logic [TIME_W-1:0] time_first;
    logic [TIME_W-1:0] time_second;
    logic [BYTE_W-1:0] rd_offset;
    logic [BYTE_W-1:0] rd_length;
    logic [CNT_W-1:0]  frame_total;
    logic [CNT_W-1:0]  skipped_frames;
  } result_t;

  typedef struct packed {
    logic [CNT_W-1:0]   frame;
    logic [TIME_W-1:0]  tstamp;
    logic [BYTE_W-1:0]  offset;
    logic [CSIZE_W-1:0] size;
    logic               key;
  } entry_t;

  typedef struct packed {
    logic [3:0] op;
    logic       capture;
  } cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             empty;
    logic             scan_done;
    logic             walk_hit;
    logic             rem_last;
  } stat_t;

endpackage

// File: hw/rtl/fir_if.sv
// Frame index ring: valid/ready channel interfaces (input, result, config).
// Depends on fir_pkg for field widths.
interface fir_in_if;
  logic                           valid;
  logic                           ready;
  logic [fir_pkg::ACT_W-1:0]      action;
  logic [fir_pkg::TIME_W-1:0]     event_time;
  logic [fir_pkg::CRC_W-1:0]      frame_crc;
  logic                           resized;
  logic                           encoded;
  logic [fir_pkg::CSIZE_W-1:0]    coded_size;
  modport source (output valid, action, event_time, frame_crc, resized, encoded, coded_size,
                  input ready);
  modport sink (input valid, action, event_time, frame_crc, resized, encoded, coded_size,
                output ready);
endinterface

interface fir_out_if;
  logic                        valid;
  logic                        ready;
  logic [fir_pkg::STAT_W-1:0]  status;
  logic [fir_pkg::CNT_W-1:0]   frame_no;
  logic                        key_mark;
  logic [fir_pkg::TIME_W-1:0]  time_first;
  logic [fir_pkg::TIME_W-1:0]  time_second;
  logic [fir_pkg::BYTE_W-1:0]  rd_offset;
  logic [fir_pkg::BYTE_W-1:0]  rd_length;
  logic [fir_pkg::CNT_W-1:0]   frame_total;
  logic [fir_pkg::CNT_W-1:0]   skipped_frames;
  modport source (output valid, status, frame_no, key_mark, time_first, time_second,
                  rd_offset, rd_length, frame_total, skipped_frames, input ready);
  modport sink (input valid, status, frame_no, key_mark, time_first, time_second,
                rd_offset, rd_length, frame_total, skipped_frames, output ready);
endinterface

interface fir_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [fir_pkg::CIDX_W-1:0]  index;
  logic [fir_pkg::CAP_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/frame_index_ring.sv
// Frame index ring: top level joining fir_ctrl and fir_dp to the channels.
// Depends on fir_pkg and the interfaces in fir_if.
//
//  channel | dir | payload                                   | transaction
//  in_ch   | in  | action, event_time, frame_crc, resized,... | valid & ready
//  out_ch  | out | status, frame_no, ... skipped_frames       | valid & ready
//  cfg     | in  | index (0 capacity, 1 key interval)        | valid & ready
//
// Frame events, unused actions and empty-index queries go from dispatch straight
// to the result; a range query reads the oldest and newest slots. A lookup scans
// every used slot, then walks back slot by slot to the keyframe; both are set by
// the single index read port. Interval write: bit-serial remainder, input held
// off meanwhile. Synchronous reset; index memory is not cleared. One transaction
// in flight; a stalled result holds the block until taken.
module frame_index_ring #(
  parameter int INDEX_DEPTH = 4096
) (
  input logic      clk,
  input logic      rst,
  fir_in_if.sink   in_ch,
  fir_out_if.source out_ch,
  fir_cfg_if.sink  cfg
);

  fir_pkg::cmd_t    cmd;
  fir_pkg::stat_t   stat;
  fir_pkg::item_t   item_in;
  fir_pkg::result_t res;

  assign item_in = '{action: in_ch.action, event_time: in_ch.event_time,
                     frame_crc: in_ch.frame_crc, resized: in_ch.resized,
                     encoded: in_ch.encoded, coded_size: in_ch.coded_size};

  fir_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready),
    .cfg_index (cfg.index),
    .stat      (stat),
    .cmd       (cmd)
  );

  fir_dp #(.INDEX_DEPTH(INDEX_DEPTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .item_in   (item_in),
    .cfg_we    (cfg.valid && cfg.ready),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .res       (res)
  );

  assign out_ch.status         = res.status;
  assign out_ch.frame_no       = res.frame_no;
  assign out_ch.key_mark       = res.key_mark;
  assign out_ch.time_first     = res.time_first;
  assign out_ch.time_second    = res.time_second;
  assign out_ch.rd_offset      = res.rd_offset;
  assign out_ch.rd_length      = res.rd_length;
  assign out_ch.frame_total    = res.frame_total;
  assign out_ch.skipped_frames = res.skipped_frames;

endmodule

// File: hw/rtl/fir_ctrl.sv
// Frame index ring: sequencing state machine.
// Depends on fir_pkg; drives commands into fir_dp and reads its status.
module fir_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  output logic                       out_valid,
  input  logic                       out_ready,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [fir_pkg::CIDX_W-1:0] cfg_index,
  input  fir_pkg::stat_t             stat,
  output fir_pkg::cmd_t              cmd
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DISPATCH  = 4'd1;
  localparam logic [3:0] S_SCAN      = 4'd2;
  localparam logic [3:0] S_WALK_INIT = 4'd3;
  localparam logic [3:0] S_WALK_RD   = 4'd4;
  localparam logic [3:0] S_WALK_CHK  = 4'd5;
  localparam logic [3:0] S_FIN_A     = 4'd6;
  localparam logic [3:0] S_FIN_B     = 4'd7;
  localparam logic [3:0] S_RNG_A     = 4'd8;
  localparam logic [3:0] S_RNG_B     = 4'd9;
  localparam logic [3:0] S_RNG_C     = 4'd10;
  localparam logic [3:0] S_RESULT    = 4'd11;
  localparam logic [3:0] S_REM       = 4'd12;

  logic [3:0] state, state_next;

  assign in_ready  = (state == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state == S_IDLE);
  assign out_valid = (state == S_RESULT);

  always_comb begin
    state_next  = state;
    cmd.op      = fir_pkg::OP_NONE;
    cmd.capture = in_valid && in_ready;
    case (state)
      S_IDLE: begin
        if (cfg_valid && cfg_index == fir_pkg::REG_KEY_INTERVAL) state_next = S_REM;
        else if (in_valid && in_ready) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (stat.action == fir_pkg::ACT_FRAME) begin
          cmd.op = fir_pkg::OP_FRAME;
          state_next = S_RESULT;
        end else if (stat.empty || !(stat.action == fir_pkg::ACT_LOOKUP ||
                                     stat.action == fir_pkg::ACT_RANGE)) begin
          cmd.op = fir_pkg::OP_PLAIN;
          state_next = S_RESULT;
        end else if (stat.action == fir_pkg::ACT_LOOKUP) begin
          cmd.op = fir_pkg::OP_SCAN_INIT;
          state_next = S_SCAN;
        end else begin
          state_next = S_RNG_A;
        end
      end
      S_SCAN: begin
        cmd.op = fir_pkg::OP_SCAN;
        if (stat.scan_done) state_next = S_WALK_INIT;
      end
      S_WALK_INIT: begin
        cmd.op = fir_pkg::OP_WALK_INIT;
        state_next = S_WALK_RD;
      end
      S_WALK_RD: begin
        cmd.op = fir_pkg::OP_WALK_RD;
        state_next = S_WALK_CHK;
      end
      S_WALK_CHK: begin
        cmd.op = fir_pkg::OP_WALK_CHK;
        state_next = stat.walk_hit ? S_FIN_A : S_WALK_RD;
      end
      S_FIN_A: begin
        cmd.op = fir_pkg::OP_FIN_A;
        state_next = S_FIN_B;
      end
      S_FIN_B: begin
        cmd.op = fir_pkg::OP_FIN_B;
        state_next = S_RESULT;
      end
      S_RNG_A: begin
        cmd.op = fir_pkg::OP_RNG_A;
        state_next = S_RNG_B;
      end
      S_RNG_B: begin
        cmd.op = fir_pkg::OP_RNG_B;
        state_next = S_RNG_C;
      end
      S_RNG_C: begin
        cmd.op = fir_pkg::OP_RNG_C;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (out_ready) state_next = S_IDLE;
      end
      S_REM: begin
        cmd.op = fir_pkg::OP_REM;
        if (stat.rem_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == S_DISPATCH)
    else $error("accepted transaction not dispatched");

  a_kfi_rem: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && cfg_index == fir_pkg::REG_KEY_INTERVAL) |=> state == S_REM)
    else $error("interval write did not start phase recompute");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && (in_ready || cfg_ready)))
    else $error("input open while result pending");

  a_scan_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && !stat.scan_done) |=> state == S_SCAN)
    else $error("scan left early");

endmodule

// File: hw/rtl/fir_dp.sv
// Frame index ring: datapath with index memory, counters and search units.
// Depends on fir_pkg; commanded by fir_ctrl.
module fir_dp #(
  parameter int INDEX_DEPTH = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  fir_pkg::cmd_t              cmd,
  output fir_pkg::stat_t             stat,
  input  fir_pkg::item_t             item_in,
  input  logic                       cfg_we,
  input  logic [fir_pkg::CIDX_W-1:0] cfg_index,
  input  logic [fir_pkg::CAP_W-1:0]  cfg_data,
  output fir_pkg::result_t           res
);

  localparam int AW = $clog2(INDEX_DEPTH);
  localparam int CW = $clog2(INDEX_DEPTH + 1);

  fir_pkg::entry_t mem [INDEX_DEPTH];
  fir_pkg::entry_t rd_data;
  fir_pkg::item_t  item;

  logic [fir_pkg::CAP_W-1:0]  capacity;
  logic [fir_pkg::KFI_W-1:0]  kfi;
  logic [AW-1:0]              write_slot;
  logic [CW-1:0]              used_slots;
  logic [fir_pkg::CNT_W-1:0]  frame_count;
  logic [fir_pkg::CNT_W-1:0]  skip_count;
  logic [fir_pkg::BYTE_W-1:0] byte_position;
  logic [fir_pkg::CRC_W-1:0]  last_crc;
  logic                       crc_known;
  logic [fir_pkg::KFI_W-1:0]  key_phase;

  logic [CW-1:0]              issue_pos, pos1, pos2, best_pos, walk_pos;
  logic [AW-1:0]              issue_slot, slot1, slot2, best_slot, walk_slot;
  logic                       v1, v2;
  logic [fir_pkg::TIME_W-1:0] cur_diff, best_dist, rng_first;
  fir_pkg::entry_t            entry2, best;
  logic [fir_pkg::BYTE_W-1:0] kf_off, rend;
  logic [fir_pkg::KFI_W-1:0]  rem;
  logic [fir_pkg::REMC_W-1:0] rem_cnt;

  logic [CW-1:0]              cap_eff;
  logic [fir_pkg::KFI_W-1:0]  kfi_eff;
  logic [CW:0]                start_wide;
  logic [AW-1:0]              start_slot, last_slot, rd_addr, issue_inc, walk_dec, ws_inc;
  logic                       dup, is_key, write_en;
  logic [fir_pkg::KFI_W-1:0]  phase_inc;
  logic [fir_pkg::KFI_W:0]    rem_trial;
  logic [fir_pkg::KFI_W-1:0]  rem_new;
  logic [fir_pkg::BYTE_W-1:0] rsize;
  logic [fir_pkg::TIME_W-1:0] d_a, d_b;

  always_comb begin
    if (capacity == '0) cap_eff = CW'(1);
    else if (32'(capacity) > 32'(INDEX_DEPTH)) cap_eff = CW'(INDEX_DEPTH);
    else cap_eff = CW'(capacity);
    kfi_eff    = (kfi == '0) ? fir_pkg::KFI_W'(1) : kfi;
    start_wide = {1'b0, CW'(write_slot)} + {1'b0, cap_eff} - {1'b0, used_slots};
    if (CW'(write_slot) >= used_slots) start_slot = AW'(CW'(write_slot) - used_slots);
    else start_slot = AW'(start_wide);
    last_slot  = (write_slot == '0) ? AW'(cap_eff - CW'(1)) : write_slot - AW'(1);
    issue_inc  = (CW'(issue_slot) + CW'(1) == cap_eff) ? '0 : issue_slot + AW'(1);
    ws_inc     = (CW'(write_slot) + CW'(1) == cap_eff) ? '0 : write_slot + AW'(1);
    walk_dec   = (walk_slot == '0) ? AW'(cap_eff - CW'(1)) : walk_slot - AW'(1);
    dup        = !item.resized && crc_known && (item.frame_crc == last_crc);
    is_key     = (key_phase == '0);
    phase_inc  = (key_phase + fir_pkg::KFI_W'(1) == kfi_eff) ? '0
                                                            : key_phase + fir_pkg::KFI_W'(1);
    write_en   = (cmd.op == fir_pkg::OP_FRAME) && !dup && item.encoded;
    rem_trial  = {rem, frame_count[fir_pkg::CNT_W - 1 - int'(rem_cnt)]};
    rem_new    = (rem_trial >= {1'b0, kfi_eff}) ? fir_pkg::KFI_W'(rem_trial - {1'b0, kfi_eff})
                                                 : fir_pkg::KFI_W'(rem_trial);
    rsize      = rend - kf_off;
    d_a        = item.event_time - rd_data.tstamp;
    d_b        = rd_data.tstamp - item.event_time;
    case (cmd.op)
      fir_pkg::OP_WALK_RD: rd_addr = walk_slot;
      fir_pkg::OP_RNG_A:   rd_addr = start_slot;
      fir_pkg::OP_RNG_B:   rd_addr = last_slot;
      default:             rd_addr = issue_slot;
    endcase
  end

  assign stat.action    = item.action;
  assign stat.empty     = (used_slots == '0);
  assign stat.scan_done = (issue_pos == used_slots) && !v1 && !v2;
  assign stat.walk_hit  = rd_data.key || (walk_pos == '0);
  assign stat.rem_last  = (rem_cnt == fir_pkg::REMC_W'(fir_pkg::CNT_W - 1));

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (write_en)
      mem[write_slot] <= '{frame: frame_count, tstamp: item.event_time,
                           offset: byte_position, size: item.coded_size, key: is_key};
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity      <= fir_pkg::CAP_W'(1200);
      kfi           <= fir_pkg::KFI_W'(4);
      write_slot    <= '0;
      used_slots    <= '0;
      frame_count   <= '0;
      skip_count    <= '0;
      byte_position <= '0;
      last_crc      <= '0;
      crc_known     <= 1'b0;
      key_phase     <= '0;
      v1            <= 1'b0;
      v2            <= 1'b0;
      issue_pos     <= '0;
      rem_cnt       <= '0;
    end else begin
      if (cfg_we && cfg_index == fir_pkg::REG_CAPACITY) begin
        capacity   <= cfg_data;
        write_slot <= '0;
        used_slots <= '0;
      end
      if (cfg_we && cfg_index == fir_pkg::REG_KEY_INTERVAL) begin
        kfi     <= cfg_data[fir_pkg::KFI_W-1:0];
        rem_cnt <= '0;
      end
      case (cmd.op)
        fir_pkg::OP_FRAME: begin
          frame_count <= frame_count + 1'b1;
          key_phase   <= phase_inc;
          if (dup) begin
            skip_count <= skip_count + 1'b1;
          end else begin
            last_crc  <= item.frame_crc;
            crc_known <= 1'b1;
            if (item.encoded) begin
              byte_position <= byte_position + fir_pkg::BYTE_W'(item.coded_size);
              write_slot    <= ws_inc;
              if (used_slots < cap_eff) used_slots <= used_slots + CW'(1);
            end
          end
        end
        fir_pkg::OP_SCAN_INIT: begin
          issue_pos <= '0;
          v1        <= 1'b0;
          v2        <= 1'b0;
        end
        fir_pkg::OP_SCAN: begin
          v1 <= (issue_pos != used_slots);
          v2 <= v1;
          if (issue_pos != used_slots) issue_pos <= issue_pos + CW'(1);
        end
        fir_pkg::OP_REM: begin
          rem_cnt <= rem_cnt + fir_pkg::REMC_W'(1);
          if (stat.rem_last) key_phase <= rem_new;
        end
        default: ;
      endcase
    end
  end

  // search and result payload
  always_ff @(posedge clk) begin
    if (cmd.capture) item <= item_in;
    if (cfg_we && cfg_index == fir_pkg::REG_KEY_INTERVAL) rem <= '0;
    case (cmd.op)
      fir_pkg::OP_FRAME: begin
        res <= '{status: dup ? fir_pkg::STAT_DUP
                             : (item.encoded ? fir_pkg::STAT_OK : fir_pkg::STAT_NOREC),
                 frame_no: frame_count,
                 key_mark: !dup && is_key,
                 time_first: '0,
                 time_second: '0,
                 rd_offset: '0,
                 rd_length: '0,
                 frame_total: frame_count + fir_pkg::CNT_W'(1),
                 skipped_frames: skip_count + fir_pkg::CNT_W'(dup)};
      end
      fir_pkg::OP_PLAIN: begin
        res <= '{status: (item.action == fir_pkg::ACT_LOOKUP ||
                          item.action == fir_pkg::ACT_RANGE) ? fir_pkg::STAT_EMPTY
                                                              : fir_pkg::STAT_NOREC,
                 frame_no: '0,
                 key_mark: 1'b0,
                 time_first: '0,
                 time_second: '0,
                 rd_offset: '0,
                 rd_length: '0,
                 frame_total: frame_count,
                 skipped_frames: skip_count};
      end
      fir_pkg::OP_SCAN_INIT: issue_slot <= start_slot;
      fir_pkg::OP_SCAN: begin
        if (issue_pos != used_slots) begin
          issue_slot <= issue_inc;
          pos1       <= issue_pos;
          slot1      <= issue_slot;
        end
        cur_diff <= (item.event_time > rd_data.tstamp) ? d_a : d_b;
        entry2   <= rd_data;
        pos2     <= pos1;
        slot2    <= slot1;
        if (v2 && (pos2 == '0 || cur_diff < best_dist)) begin
          best_dist <= cur_diff;
          best_pos  <= pos2;
          best_slot <= slot2;
          best      <= entry2;
        end
      end
      fir_pkg::OP_WALK_INIT: begin
        walk_pos  <= best_pos;
        walk_slot <= best_slot;
      end
      fir_pkg::OP_WALK_CHK: begin
        if (rd_data.key) kf_off <= rd_data.offset;
        else if (walk_pos == '0) kf_off <= best.offset;
        else begin
          walk_pos  <= walk_pos - CW'(1);
          walk_slot <= walk_dec;
        end
      end
      fir_pkg::OP_FIN_A: rend <= best.offset + fir_pkg::BYTE_W'(best.size);
      fir_pkg::OP_FIN_B: begin
        res <= '{status: (rsize == '0 || rsize > fir_pkg::MAX_READ_BYTES)
                         ? fir_pkg::STAT_BADSIZE : fir_pkg::STAT_OK,
                 frame_no: best.frame,
                 key_mark: best.key,
                 time_first: best.tstamp,
                 time_second: '0,
                 rd_offset: kf_off,
                 rd_length: rsize,
                 frame_total: frame_count,
                 skipped_frames: skip_count};
      end
      fir_pkg::OP_RNG_B: rng_first <= rd_data.tstamp;
      fir_pkg::OP_RNG_C: begin
        res <= '{status: fir_pkg::STAT_OK,
                 frame_no: '0,
                 key_mark: 1'b0,
                 time_first: rng_first,
                 time_second: rd_data.tstamp,
                 rd_offset: '0,
                 rd_length: '0,
                 frame_total: frame_count,
                 skipped_frames: skip_count};
      end
      fir_pkg::OP_REM: rem <= rem_new;
      default: ;
    endcase
  end

  a_ring_bounds: assert property (@(posedge clk) disable iff (rst)
    (used_slots <= cap_eff) && (CW'(write_slot) < cap_eff))
    else $error("ring pointers out of range");

endmodule

// File: bench/frame_index_ring_tb.sv
// Testbench for frame_index_ring: directed and random frame, lookup and range
// transactions checked against an in-bench ring index predictor.
// Depends on fir_pkg, the channel interfaces in fir_if and the block's RTL.
`timescale 1ns / 100ps

module frame_index_ring_tb;

  localparam int DEPTH = 4096;
  localparam logic [fir_pkg::ACT_W-1:0]  ACT_SPARE = 2'd3;
  localparam logic [fir_pkg::CIDX_W-1:0] REG_SPARE = 2'd3;

  class ring_index_board;
    logic [fir_pkg::CNT_W-1:0]   ent_frame [DEPTH];
    logic [fir_pkg::TIME_W-1:0]  ent_time [DEPTH];
    logic [fir_pkg::BYTE_W-1:0]  ent_off [DEPTH];
    logic [fir_pkg::CSIZE_W-1:0] ent_size [DEPTH];
    logic                        ent_key [DEPTH];
    int unsigned wr_slot, used, cap_reg, kfi_reg;
    logic [fir_pkg::CNT_W-1:0]  frames, skips;
    logic [fir_pkg::BYTE_W-1:0] byte_pos;
    logic [fir_pkg::CRC_W-1:0]  prev_crc;
    bit                         crc_valid;
    fir_pkg::result_t           pending[$];
    int                         errors;

    function new();
      wr_slot = 0; used = 0; cap_reg = 1200; kfi_reg = 4;
      frames = '0; skips = '0; byte_pos = '0; prev_crc = '0; crc_valid = 0;
      errors = 0;
    endfunction

    function int unsigned eff_cap();
      if (cap_reg == 0) return 1;
      if (cap_reg > DEPTH) return DEPTH;
      return cap_reg;
    endfunction

    function int unsigned pos_slot(int unsigned pos);
      int unsigned c, start;
      c = eff_cap();
      start = (wr_slot >= used) ? wr_slot - used : wr_slot + c - used;
      return (start + pos) % c;
    endfunction

    function void write_reg(logic [fir_pkg::CIDX_W-1:0] idx, logic [fir_pkg::CAP_W-1:0] val);
      if (idx == fir_pkg::REG_CAPACITY) begin
        cap_reg = 32'(val);
        wr_slot = 0;
        used = 0;
      end else if (idx == fir_pkg::REG_KEY_INTERVAL) begin
        kfi_reg = 32'(val[fir_pkg::KFI_W-1:0]);
      end
    endfunction

    function void note_input(fir_pkg::item_t it);
      fir_pkg::result_t r;
      logic [fir_pkg::CNT_W-1:0] kfi;
      logic [fir_pkg::TIME_W-1:0] d, best_d;
      logic [fir_pkg::BYTE_W-1:0] rend, rsize;
      int unsigned s, best, tgt, kf, i;
      bit key, found;
      r = '0;
      case (it.action)
        fir_pkg::ACT_FRAME: begin
          r.frame_no = frames;
          if (it.resized) crc_valid = 0;
          if (crc_valid && it.frame_crc == prev_crc) begin
            skips++;
            r.status = fir_pkg::STAT_DUP;
          end else begin
            kfi = (kfi_reg == 0) ? 64'd1 : 64'(kfi_reg);
            key = (frames % kfi) == 0;
            prev_crc = it.frame_crc;
            crc_valid = 1;
            r.key_mark = key;
            if (it.encoded) begin
              s = wr_slot % eff_cap();
              ent_frame[s] = frames;
              ent_time[s] = it.event_time;
              ent_off[s] = byte_pos;
              ent_size[s] = it.coded_size;
              ent_key[s] = key;
              byte_pos = byte_pos + fir_pkg::BYTE_W'(it.coded_size);
              wr_slot = (s + 1) % eff_cap();
              if (used < eff_cap()) used++;
              r.status = fir_pkg::STAT_OK;
            end else begin
              r.status = fir_pkg::STAT_NOREC;
            end
          end
          frames++;
        end
        fir_pkg::ACT_LOOKUP: begin
          if (used == 0) begin
            r.status = fir_pkg::STAT_EMPTY;
          end else begin
            best = 0;
            best_d = '0;
            for (i = 0; i < used; i++) begin
              s = pos_slot(i);
              d = (it.event_time > ent_time[s]) ? it.event_time - ent_time[s]
                                                : ent_time[s] - it.event_time;
              if (i == 0 || d < best_d) begin
                best_d = d;
                best = i;
              end
            end
            tgt = pos_slot(best);
            kf = tgt;
            found = 0;
            for (i = best + 1; i > 0 && !found; i--) begin
              s = pos_slot(i - 1);
              if (ent_key[s]) begin
                kf = s;
                found = 1;
              end
            end
            rend = ent_off[tgt] + fir_pkg::BYTE_W'(ent_size[tgt]);
            rsize = rend - ent_off[kf];
            r.status = (rsize == '0 || rsize > fir_pkg::MAX_READ_BYTES) ? fir_pkg::STAT_BADSIZE
                                                                       : fir_pkg::STAT_OK;
            r.frame_no = ent_frame[tgt];
            r.key_mark = ent_key[tgt];
            r.time_first = ent_time[tgt];
            r.rd_offset = ent_off[kf];
            r.rd_length = rsize;
          end
        end
        fir_pkg::ACT_RANGE: begin
          if (used == 0) begin
            r.status = fir_pkg::STAT_EMPTY;
          end else begin
            r.status = fir_pkg::STAT_OK;
            r.time_first = ent_time[pos_slot(0)];
            r.time_second = ent_time[pos_slot(used - 1)];
          end
        end
        default: r.status = fir_pkg::STAT_NOREC;
      endcase
      r.frame_total = frames;
      r.skipped_frames = skips;
      pending.push_back(r);
    endfunction

    function void cmp(string name, logic [fir_pkg::CNT_W-1:0] exp_v,
                      logic [fir_pkg::CNT_W-1:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(fir_pkg::result_t got);
      fir_pkg::result_t e;
      if (pending.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      cmp("status", 64'(e.status), 64'(got.status));
      cmp("frame_no", e.frame_no, got.frame_no);
      cmp("key_mark", 64'(e.key_mark), 64'(got.key_mark));
      cmp("time_first", 64'(e.time_first), 64'(got.time_first));
      cmp("time_second", 64'(e.time_second), 64'(got.time_second));
      cmp("rd_offset", 64'(e.rd_offset), 64'(got.rd_offset));
      cmp("rd_length", 64'(e.rd_length), 64'(got.rd_length));
      cmp("frame_total", e.frame_total, got.frame_total);
      cmp("skipped_frames", e.skipped_frames, got.skipped_frames);
    endfunction
  endclass

  logic clk;
  logic rst;
  fir_in_if  in_ch ();
  fir_out_if out_ch ();
  fir_cfg_if cfg ();

  frame_index_ring i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg    (cfg.sink)
  );

  ring_index_board board;
  logic [fir_pkg::TIME_W-1:0] clock_ns;
  logic [fir_pkg::CRC_W-1:0]  run_crc;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  task automatic send_item(fir_pkg::item_t it);
    int gap;
    in_ch.valid      <= 1'b1;
    in_ch.action     <= it.action;
    in_ch.event_time <= it.event_time;
    in_ch.frame_crc  <= it.frame_crc;
    in_ch.resized    <= it.resized;
    in_ch.encoded    <= it.encoded;
    in_ch.coded_size <= it.coded_size;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_input(it);
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_cfg(logic [fir_pkg::CIDX_W-1:0] idx, logic [fir_pkg::CAP_W-1:0] val);
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    board.write_reg(idx, val);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic fir_pkg::item_t mk(logic [fir_pkg::ACT_W-1:0] act,
                                        logic [fir_pkg::TIME_W-1:0] t,
                                        logic [fir_pkg::CRC_W-1:0] crc, bit rs, bit en,
                                        logic [fir_pkg::CSIZE_W-1:0] sz);
    fir_pkg::item_t it;
    it.action = act; it.event_time = t; it.frame_crc = crc;
    it.resized = rs; it.encoded = en; it.coded_size = sz;
    return it;
  endfunction

  function automatic fir_pkg::item_t rand_item();
    fir_pkg::item_t it;
    logic [63:0] w;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      w = {$urandom(), $urandom()};
      it.action = fir_pkg::ACT_W'($urandom_range(0, 3));
      it.event_time = w[fir_pkg::TIME_W-1:0];
      it.frame_crc = $urandom();
      it.resized = 1'($urandom_range(0, 1));
      it.encoded = 1'($urandom_range(0, 1));
      it.coded_size = fir_pkg::CSIZE_W'($urandom());
    end else if (pick < 70) begin
      clock_ns = clock_ns + fir_pkg::TIME_W'($urandom_range(0, 40000000));
      if ($urandom_range(0, 4) != 0) run_crc = $urandom();
      it = mk(fir_pkg::ACT_FRAME, clock_ns, run_crc, $urandom_range(0, 9) == 0,
              $urandom_range(0, 6) != 0,
              ($urandom_range(0, 7) == 0) ? fir_pkg::CSIZE_W'($urandom())
                                          : fir_pkg::CSIZE_W'($urandom_range(0, 1 << 21)));
    end else if (pick < 88) begin
      w = 64'(clock_ns) - 64'($urandom_range(0, 500000000)) + 64'($urandom_range(0, 60000000));
      it = mk(fir_pkg::ACT_LOOKUP, w[fir_pkg::TIME_W-1:0], $urandom(),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              fir_pkg::CSIZE_W'($urandom()));
    end else begin
      it = mk(fir_pkg::ACT_RANGE, clock_ns, $urandom(), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), fir_pkg::CSIZE_W'($urandom()));
    end
    return it;
  endfunction

  always @(posedge clk) begin
    fir_pkg::result_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.status = out_ch.status;
      got.frame_no = out_ch.frame_no;
      got.key_mark = out_ch.key_mark;
      got.time_first = out_ch.time_first;
      got.time_second = out_ch.time_second;
      got.rd_offset = out_ch.rd_offset;
      got.rd_length = out_ch.rd_length;
      got.frame_total = out_ch.frame_total;
      got.skipped_frames = out_ch.skipped_frames;
      board.check_result(got);
    end
  end

  initial begin
    int stall;
    @(negedge rst);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  initial begin
    logic [fir_pkg::TIME_W-1:0] tmax;
    logic [fir_pkg::CAP_W-1:0] caps [7];
    logic [fir_pkg::CAP_W-1:0] kfis [7];
    board = new();
    tmax = '1;
    clock_ns = '0;
    run_crc = '0;
    rst = 1'b1;
    in_ch.valid = 1'b0; in_ch.action = fir_pkg::ACT_FRAME; in_ch.event_time = '0;
    in_ch.frame_crc = '0; in_ch.resized = 1'b0; in_ch.encoded = 1'b0;
    in_ch.coded_size = '0;
    out_ch.ready = 1'b0;
    cfg.valid = 1'b0; cfg.index = fir_pkg::REG_CAPACITY; cfg.data = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty index, unused action, size and time extremes, ties, duplicates
    send_item(mk(fir_pkg::ACT_RANGE, '0, '0, 0, 0, '0));
    send_item(mk(fir_pkg::ACT_LOOKUP, tmax, '1, 1, 1, '1));
    send_item(mk(ACT_SPARE, tmax, '1, 1, 1, '1));
    send_item(mk(fir_pkg::ACT_FRAME, '0, '0, 0, 1, '0));
    send_item(mk(fir_pkg::ACT_LOOKUP, '0, '0, 0, 0, '0));
    send_item(mk(fir_pkg::ACT_FRAME, 63'd10, '0, 0, 1, 26'd5));
    send_item(mk(fir_pkg::ACT_FRAME, 63'd10, '0, 1, 1, '1));
    send_item(mk(fir_pkg::ACT_FRAME, 63'd10, '1, 0, 0, 26'd7));
    send_item(mk(fir_pkg::ACT_FRAME, 63'd20, 32'h1234, 0, 1, '1));
    send_item(mk(fir_pkg::ACT_LOOKUP, 63'd10, '0, 0, 0, '0));
    send_item(mk(fir_pkg::ACT_LOOKUP, 63'd15, '0, 0, 0, '0));
    send_item(mk(fir_pkg::ACT_LOOKUP, 63'd19, '0, 0, 0, '0));
    send_item(mk(fir_pkg::ACT_FRAME, tmax, '1, 0, 1, '1));
    send_item(mk(fir_pkg::ACT_FRAME, tmax, 32'h5555, 0, 1, 26'd1));
    send_item(mk(fir_pkg::ACT_LOOKUP, tmax, '0, 0, 0, '0));
    send_item(mk(fir_pkg::ACT_LOOKUP, tmax - 63'd1, '0, 0, 0, '0));
    send_item(mk(fir_pkg::ACT_RANGE, '0, '0, 0, 0, '0));
    send_item(mk(ACT_SPARE, '0, '0, 0, 0, '0));

    caps = '{13'd1, 13'd5, 13'd4096, 13'd0, 13'd8191, 13'd3, 13'd1200};
    kfis = '{13'd1, 13'd0, 13'd1023, 13'd3, 13'h1c07, 13'd4, 13'd2};
    for (int ph = 0; ph < 7; ph++) begin
      write_cfg(fir_pkg::REG_CAPACITY, caps[ph]);
      write_cfg(fir_pkg::REG_KEY_INTERVAL, kfis[ph]);
      if (ph == 3) write_cfg(REG_SPARE, '1);
      for (int n = 0; n < 18; n++) send_item(rand_item());
    end

    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: frame_index_ring.f
hw/rtl/fir_pkg.sv
hw/rtl/fir_if.sv
hw/rtl/fir_ctrl.sv
hw/rtl/fir_dp.sv
hw/rtl/frame_index_ring.sv
bench/frame_index_ring_tb.sv
